### design/iipr_pkg.sv
// Package for the indexed image to printer raster block.
// Holds shared types, codes and the escape sequence ROM; no dependencies.
package iipr_pkg;

  // Geometry of one pixel row
  localparam int RowBytes     = 128;
  localparam int WordsPerRow  = RowBytes / 4;
  localparam int ColW         = $clog2(RowBytes);
  localparam int AddrW        = $clog2(WordsPerRow);
  localparam int CntW         = $clog2(WordsPerRow);

  // Register indexes on the configuration port
  localparam logic [1:0] RegRowCount     = 2'd0;
  localparam logic [1:0] RegHeaderLength = 2'd1;
  localparam logic [1:0] RegWhiteLevel   = 2'd2;

  // Register reset values
  localparam logic [7:0] RowCountRst     = 8'd212;
  localparam logic [3:0] HeaderLengthRst = 4'd7;
  localparam logic [3:0] WhiteLevelRst   = 4'd15;

  // Sequence ROM layout: init words, row header words, end words
  localparam logic [5:0] InitBase = 6'd0;
  localparam logic [5:0] HdrBase  = 6'd27;
  localparam logic [5:0] EndBase  = 6'd30;
  localparam logic [CntW-1:0] InitLast  = CntW'(26);
  localparam logic [CntW-1:0] HdrLast   = CntW'(2);
  localparam logic [CntW-1:0] EndLast   = CntW'(7);
  localparam logic [CntW-1:0] ReplayLast = CntW'(WordsPerRow - 1);

  localparam logic [1:0] BvFull = 2'd2;
  localparam logic [1:0] BvHalf = 2'd1;

  // Pending segment bits, lowest bit is sent first
  localparam int PbInit = 0;
  localparam int PbHdr1 = 1;
  localparam int PbWord = 2;
  localparam int PbHdr2 = 3;
  localparam int PbEnd  = 4;
  localparam int PendW  = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_HDR1,
    ST_WORD,
    ST_HDR2,
    ST_REPLAY,
    ST_END
  } seq_state_t;

  // Work handed from the byte front end to the sequencer
  typedef struct packed {
    logic [PendW-1:0] pend;
    logic [15:0]      word;
  } job_t;

  // First segment to run for a pending mask
  function automatic seq_state_t first_seg(input logic [PendW-1:0] pend);
    seq_state_t s;
    s = ST_IDLE;
    if (pend[PbInit])      s = ST_INIT;
    else if (pend[PbHdr1]) s = ST_HDR1;
    else if (pend[PbWord]) s = ST_WORD;
    else if (pend[PbHdr2]) s = ST_HDR2;
    else if (pend[PbEnd])  s = ST_END;
    return s;
  endfunction

  // Init escape sequence, row header and end sequence packed two bytes a word
  function automatic logic [15:0] seq_rom(input logic [5:0] idx);
    logic [15:0] w;
    case (idx)
      6'd0:  w = 16'h1B25;
      6'd1:  w = 16'h2D31;
      6'd2:  w = 16'h3233;
      6'd3:  w = 16'h3435;
      6'd4:  w = 16'h581B;
      6'd5:  w = 16'h451B;
      6'd6:  w = 16'h266C;
      6'd7:  w = 16'h3236;
      6'd8:  w = 16'h411B;
      6'd9:  w = 16'h266C;
      6'd10: w = 16'h314F;
      6'd11: w = 16'h1B26;
      6'd12: w = 16'h6C31;
      6'd13: w = 16'h451B;
      6'd14: w = 16'h2A70;
      6'd15: w = 16'h3637;
      6'd16: w = 16'h3878;
      6'd17: w = 16'h3334;
      6'd18: w = 16'h3059;
      6'd19: w = 16'h1B2A;
      6'd20: w = 16'h7437;
      6'd21: w = 16'h3552;
      6'd22: w = 16'h1B2A;
      6'd23: w = 16'h7230;
      6'd24: w = 16'h461B;
      6'd25: w = 16'h2A72;
      6'd26: w = 16'h3141;
      6'd27: w = 16'h1B2A;
      6'd28: w = 16'h6236;
      6'd29: w = 16'h3457;
      6'd30: w = 16'h1B2A;
      6'd31: w = 16'h7243;
      6'd32: w = 16'h1B45;
      6'd33: w = 16'h1B25;
      6'd34: w = 16'h2D31;
      6'd35: w = 16'h3233;
      6'd36: w = 16'h3435;
      6'd37: w = 16'h5800;
      default: w = 16'h0000;
    endcase
    return w;
  endfunction

endpackage

### design/iipr_linemem.sv
// Line store: one row of packed pixel words, one write and one read port.
// Depends on iipr_pkg for the depth; read data is registered.
module iipr_linemem (
  input  logic                      clk,
  input  logic                      we,
  input  logic [iipr_pkg::AddrW-1:0] waddr,
  input  logic [15:0]               wdata,
  input  logic                      re,
  input  logic [iipr_pkg::AddrW-1:0] raddr,
  output logic [15:0]               rdata
);

  logic [15:0] mem [iipr_pkg::WordsPerRow];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/iipr_pixel.sv
// Byte front end: file phase, header skip, pixel packing and row counting.
// Depends on iipr_pkg; writes finished words into the line store.
module iipr_pixel (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [7:0]                 data_byte,
  input  logic [7:0]                 row_count,
  input  logic [3:0]                 header_length,
  input  logic [3:0]                 white_level,
  output iipr_pkg::job_t             job,
  output logic                       mem_we,
  output logic [iipr_pkg::AddrW-1:0] mem_waddr,
  output logic [15:0]                mem_wdata
);

  logic                      phase, phase_next;
  logic [3:0]                header_seen, header_seen_next;
  logic [iipr_pkg::ColW-1:0] column, column_next;
  logic [7:0]                row_index, row_index_next;
  logic [15:0]               partial_word, partial_word_next;

  logic                      init;
  logic [3:0]                hs_eff;
  logic [iipr_pkg::ColW-1:0] col_eff;
  logic [7:0]                row_eff, row_inc;
  logic [15:0]               pw_eff, base, word_new;
  logic [1:0]                slot;
  logic [3:0]                nib, sh;
  logic                      skip, row_end, file_end;

  // state as seen by this byte: a new file starts from zero
  always_comb begin
    init    = !phase;
    hs_eff  = init ? 4'd0 : header_seen;
    col_eff = init ? '0 : column;
    row_eff = init ? 8'd0 : row_index;
    pw_eff  = init ? 16'd0 : partial_word;
    skip    = hs_eff < header_length;
    slot    = col_eff[1:0];
    base    = (slot == 2'd0) ? 16'd0 : pw_eff;
    nib     = {{2{data_byte[7:4] < white_level}}, {2{data_byte[3:0] < white_level}}};
    sh      = {~slot, 2'b00};
    word_new = base | (16'(nib) << sh);
    row_end  = (col_eff == iipr_pkg::ColW'(iipr_pkg::RowBytes - 1));
    row_inc  = row_eff + 8'd1;
    file_end = row_end && (row_inc == row_count);
  end

  // next state and the segments this byte causes
  always_comb begin
    phase_next        = 1'b1;
    header_seen_next  = hs_eff;
    column_next       = col_eff;
    row_index_next    = row_eff;
    partial_word_next = pw_eff;
    job.pend          = '0;
    job.word          = word_new;
    job.pend[iipr_pkg::PbInit] = init;
    mem_we    = 1'b0;
    mem_waddr = col_eff[iipr_pkg::ColW-1:2];
    mem_wdata = word_new;
    if (skip) begin
      header_seen_next = hs_eff + 4'd1;
    end else begin
      job.pend[iipr_pkg::PbHdr1] = (col_eff == '0);
      job.pend[iipr_pkg::PbWord] = (slot == 2'd3);
      mem_we            = accept && (slot == 2'd3);
      partial_word_next = word_new;
      if (row_end) begin
        job.pend[iipr_pkg::PbHdr2] = 1'b1;
        column_next    = '0;
        row_index_next = row_inc;
        if (file_end) begin
          job.pend[iipr_pkg::PbEnd] = 1'b1;
          phase_next        = 1'b0;
          header_seen_next  = 4'd0;
          row_index_next    = 8'd0;
          partial_word_next = 16'd0;
        end
      end else begin
        column_next = col_eff + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= 1'b0;
      header_seen  <= 4'd0;
      column       <= '0;
      row_index    <= 8'd0;
      partial_word <= 16'd0;
    end else if (accept) begin
      phase        <= phase_next;
      header_seen  <= header_seen_next;
      column       <= column_next;
      row_index    <= row_index_next;
      partial_word <= partial_word_next;
    end
  end

endmodule

### design/iipr_seq.sv
// Output sequencer: walks the pending segments one word a cycle while stage one is free,
// replays the line store, and feeds a two-register output pipe. Depends on iipr_pkg.
module iipr_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       job_load,
  input  iipr_pkg::job_t             job,
  output logic                       idle,
  output logic                       mem_re,
  output logic [iipr_pkg::AddrW-1:0] mem_raddr,
  input  logic [15:0]                mem_rdata,
  output logic                       word_valid,
  input  logic                       word_ready,
  output logic [15:0]                out_word,
  output logic [1:0]                 bytes_valid,
  output logic                       run_last,
  output logic                       job_last
);

  iipr_pkg::seq_state_t      state, state_next;
  logic [iipr_pkg::PendW-1:0] pend, pend_next;
  logic [iipr_pkg::CntW-1:0] cnt, cnt_next;
  logic [15:0]               word_hold;

  // stage one of the output pipe
  logic        s1_valid, s1_mem, s1_rl, s1_jl;
  logic [15:0] s1_word;
  logic [1:0]  s1_bv;

  logic        out_free, s1_free, beat;
  logic [5:0]  rom_idx;
  logic [15:0] b_word;
  logic        b_mem, b_seg_last, b_rl, b_jl;
  logic [1:0]  b_bv;

  assign out_free = !word_valid || word_ready;
  assign s1_free  = !s1_valid || out_free;
  assign idle     = (state == iipr_pkg::ST_IDLE) && (pend == '0);

  // beat contents for the current segment
  always_comb begin
    rom_idx    = iipr_pkg::InitBase + 6'(cnt);
    b_mem      = 1'b0;
    b_seg_last = 1'b0;
    b_bv       = iipr_pkg::BvFull;
    b_jl       = 1'b0;
    case (state)
      iipr_pkg::ST_INIT: begin
        b_seg_last = (cnt == iipr_pkg::InitLast);
      end
      iipr_pkg::ST_HDR1, iipr_pkg::ST_HDR2: begin
        rom_idx    = iipr_pkg::HdrBase + 6'(cnt);
        b_seg_last = (cnt == iipr_pkg::HdrLast);
      end
      iipr_pkg::ST_WORD: begin
        b_seg_last = 1'b1;
      end
      iipr_pkg::ST_REPLAY: begin
        b_mem      = 1'b1;
        b_seg_last = (cnt == iipr_pkg::ReplayLast);
      end
      iipr_pkg::ST_END: begin
        rom_idx    = iipr_pkg::EndBase + 6'(cnt);
        b_seg_last = (cnt == iipr_pkg::EndLast);
        b_bv       = b_seg_last ? iipr_pkg::BvHalf : iipr_pkg::BvFull;
        b_jl       = b_seg_last;
      end
      default: begin
        b_seg_last = 1'b0;
      end
    endcase
    b_word = (state == iipr_pkg::ST_WORD) ? word_hold : iipr_pkg::seq_rom(rom_idx);
    b_rl   = b_seg_last && (pend == '0) && (state != iipr_pkg::ST_HDR2);
    beat   = s1_free && (state != iipr_pkg::ST_IDLE);
  end

  assign mem_re    = beat && b_mem;
  assign mem_raddr = cnt[iipr_pkg::AddrW-1:0];

  // segment walk
  always_comb begin
    state_next = state;
    pend_next  = pend;
    cnt_next   = cnt;
    if (job_load) begin
      pend_next = job.pend;
    end else if (state == iipr_pkg::ST_IDLE) begin
      if (pend != '0) begin
        state_next = iipr_pkg::first_seg(pend);
        pend_next  = pend & (pend - 1'b1);
        cnt_next   = '0;
      end
    end else if (beat) begin
      if (b_seg_last) begin
        cnt_next = '0;
        if (state == iipr_pkg::ST_HDR2) begin
          state_next = iipr_pkg::ST_REPLAY;
        end else begin
          state_next = iipr_pkg::first_seg(pend);
          pend_next  = pend & (pend - 1'b1);
        end
      end else begin
        cnt_next = cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iipr_pkg::ST_IDLE;
      pend  <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      word_hold <= job.word;
    end
  end

  // stage one register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      s1_word <= b_word;
      s1_mem  <= b_mem;
      s1_bv   <= b_bv;
      s1_rl   <= b_rl;
      s1_jl   <= b_jl;
    end
  end

  // output register, line store data joins here
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (out_free) begin
      word_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_word    <= s1_mem ? mem_rdata : s1_word;
      bytes_valid <= s1_bv;
      run_last    <= s1_rl;
      job_last    <= s1_jl;
    end
  end

endmodule

### design/indexed_image_to_printer_raster.sv
// Indexed image to printer raster converter, top level.
// Result words pass the pending mask, sequencer state, stage one and output register.
// Throughput: bytes with no result are taken one a cycle; after one with results, the
// next byte waits for an idle sequencer, which sends one word a cycle unless stalled.
// Reset (rst, synchronous): registers to defaults, file state to awaiting a new file.
module indexed_image_to_printer_raster (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  data_byte,
  output logic        word_valid,
  input  logic        word_ready,
  output logic [15:0] out_word,
  output logic [1:0]  bytes_valid,
  output logic        run_last,
  output logic        job_last,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] row_count;
  logic [3:0] header_length;
  logic [3:0] white_level;

  logic                       accept, idle;
  iipr_pkg::job_t             job;
  logic                       mem_we, mem_re;
  logic [iipr_pkg::AddrW-1:0] mem_waddr, mem_raddr;
  logic [15:0]                mem_wdata, mem_rdata;

  assign byte_ready = idle;
  assign accept     = byte_valid && idle;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count     <= iipr_pkg::RowCountRst;
      header_length <= iipr_pkg::HeaderLengthRst;
      white_level   <= iipr_pkg::WhiteLevelRst;
    end else if (cfg_write) begin
      case (cfg_index)
        iipr_pkg::RegRowCount:     row_count     <= cfg_data;
        iipr_pkg::RegHeaderLength: header_length <= cfg_data[3:0];
        iipr_pkg::RegWhiteLevel:   white_level   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  iipr_pixel u_pixel (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (data_byte),
    .row_count     (row_count),
    .header_length (header_length),
    .white_level   (white_level),
    .job           (job),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata)
  );

  iipr_linemem u_linemem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  iipr_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .job_load    (accept),
    .job         (job),
    .idle        (idle),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .word_valid  (word_valid),
    .word_ready  (word_ready),
    .out_word    (out_word),
    .bytes_valid (bytes_valid),
    .run_last    (run_last),
    .job_last    (job_last)
  );

endmodule

### bench/tb.sv
// Testbench for indexed_image_to_printer_raster: byte stream in, raster words out.
// Checks every output beat against an in-bench model of the converter.
// Depends on iipr_pkg (register indexes, reset values, byte counts per word).
`timescale 1ns / 100ps

module tb;

  localparam int CycleLimit = 4000000;

  // Escape sequences, first byte in the top bits
  localparam logic [54*8-1:0] InitSeq = {8'h1B, "%-12345X", 8'h1B, "E",
    8'h1B, "&l26A", 8'h1B, "&l1O", 8'h1B, "&l1E", 8'h1B, "*p678x340Y",
    8'h1B, "*t75R", 8'h1B, "*r0F", 8'h1B, "*r1A"};
  localparam logic [6*8-1:0]  RowHdrSeq = {8'h1B, "*b64W"};
  localparam logic [15*8-1:0] EndSeq = {8'h1B, "*rC", 8'h1B, "E", 8'h1B, "%-12345X"};

  typedef struct packed {
    logic [15:0] word;
    logic [1:0]  bv;
    logic        rl;
    logic        jl;
  } raster_word_t;

  typedef enum logic {STEP_BYTE, STEP_REG} step_kind_t;

  typedef struct packed {
    step_kind_t  kind;
    logic [1:0]  idx;
    logic [7:0]  data;
    int          exp_n;
    logic        chk_w;
    logic [15:0] exp_w;
  } step_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        byte_valid;
  logic        byte_ready;
  logic [7:0]  data_byte;
  logic        word_valid;
  logic        word_ready;
  logic [15:0] out_word;
  logic [1:0]  bytes_valid;
  logic        run_last;
  logic        job_last;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  indexed_image_to_printer_raster uut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .data_byte   (data_byte),
    .word_valid  (word_valid),
    .word_ready  (word_ready),
    .out_word    (out_word),
    .bytes_valid (bytes_valid),
    .run_last    (run_last),
    .job_last    (job_last),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow registers and converter state
  logic [7:0]  sh_rows;
  logic [3:0]  sh_hdr_len;
  logic [3:0]  sh_white;
  logic        in_file;
  logic [3:0]  hdr_seen;
  logic [6:0]  col;
  logic [7:0]  rows_done;
  logic [15:0] acc_word;
  logic [15:0] line_words [iipr_pkg::WordsPerRow];

  raster_word_t raster_q[$];
  raster_word_t held_word;
  logic         held_valid;
  int           run_len;
  logic [15:0]  run_first;

  int  mismatch_count = 0;
  int  words_seen = 0;
  int  cycles = 0;
  int  burst_left = 0;
  step_t steps[$];

  task automatic flag(input string what, input int got, input int want);
    mismatch_count++;
    $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // One expected word; the previous one is released so that the last of a run
  // can be marked when the byte is done
  task automatic add_word(input logic [15:0] w, input logic [1:0] bv, input logic jl);
    if (held_valid) raster_q.push_back(held_word);
    else run_first = w;
    held_word  = '{word: w, bv: bv, rl: 1'b0, jl: jl};
    held_valid = 1'b1;
    run_len++;
  endtask

  task automatic add_seq(input logic [54*8-1:0] s, input int len, input logic jl);
    int i;
    for (i = 0; i < len; i += 2) begin
      if (i + 1 < len)
        add_word({s[(len-1-i)*8 +: 8], s[(len-2-i)*8 +: 8]}, iipr_pkg::BvFull, 1'b0);
      else
        add_word({s[(len-1-i)*8 +: 8], 8'h00}, iipr_pkg::BvHalf, jl);
    end
  endtask

  // Expected words for one accepted file byte
  task automatic convert_byte(input logic [7:0] b);
    logic [3:0] hi;
    logic [3:0] lo;
    logic [1:0] slot;
    int shift;
    int i;
    hi = b[7:4];
    lo = b[3:0];
    run_len = 0;
    held_valid = 1'b0;
    if (!in_file) begin
      add_seq(InitSeq, 54, 1'b0);
      in_file   = 1'b1;
      hdr_seen  = '0;
      col       = '0;
      rows_done = '0;
      acc_word  = '0;
    end
    if (hdr_seen < sh_hdr_len) begin
      hdr_seen = hdr_seen + 4'd1;
    end else begin
      if (col == 0) add_seq((54*8)'(RowHdrSeq), 6, 1'b0);
      slot = col[1:0];
      if (slot == 0) acc_word = '0;
      shift = 14 - 4 * slot;
      if (hi < sh_white) acc_word |= 16'h3 << shift;
      if (lo < sh_white) acc_word |= 16'h3 << (shift - 2);
      if (slot == 3) begin
        line_words[col[6:2]] = acc_word;
        add_word(acc_word, iipr_pkg::BvFull, 1'b0);
      end
      if (col == 7'(iipr_pkg::RowBytes - 1)) begin
        // row end: header again, then the stored row
        add_seq((54*8)'(RowHdrSeq), 6, 1'b0);
        for (i = 0; i < iipr_pkg::WordsPerRow; i++)
          add_word(line_words[i], iipr_pkg::BvFull, 1'b0);
        col = '0;
        rows_done = rows_done + 8'd1;
        if (rows_done == sh_rows) begin
          add_seq((54*8)'(EndSeq), 15, 1'b1);
          in_file   = 1'b0;
          hdr_seen  = '0;
          rows_done = '0;
          acc_word  = '0;
        end
      end else begin
        col = col + 7'd1;
      end
    end
    if (held_valid) begin
      held_word.rl = 1'b1;
      raster_q.push_back(held_word);
    end
  endtask

  // Beat on the byte channel; valid stays high for the caller to lower
  task automatic send_beat(input logic [7:0] b);
    byte_valid <= 1'b1;
    data_byte  <= b;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    convert_byte(b);
  endtask

  // Sender bursts with random gaps
  task automatic pace();
    burst_left--;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 3) != 0) begin
        byte_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
  endtask

  // Wait for all expected words, then for the tail of a silent byte
  task automatic settle();
    byte_valid <= 1'b0;
    while (raster_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [7:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      iipr_pkg::RegRowCount:     sh_rows    = val;
      iipr_pkg::RegHeaderLength: sh_hdr_len = val[3:0];
      iipr_pkg::RegWhiteLevel:   sh_white   = val[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic add_step(input step_kind_t k, input logic [1:0] idx, input logic [7:0] d,
                          input int n, input logic chk, input logic [15:0] w);
    steps.push_back('{kind: k, idx: idx, data: d, exp_n: n, chk_w: chk, exp_w: w});
  endtask

  // Pixel byte in one of several flavors
  function automatic logic [7:0] pick_byte(input int flavor);
    logic [3:0] a;
    logic [3:0] b;
    case (flavor)
      0: return 8'($urandom_range(0, 255));
      1: begin
        case ($urandom_range(0, 3))
          0: return 8'h00;
          1: return 8'hFF;
          2: return 8'h0F;
          default: return 8'hF0;
        endcase
      end
      default: begin
        // nibbles straddling the white threshold
        a = ($urandom_range(0, 1) == 0) ? sh_white : sh_white - 4'd1;
        b = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15)) : sh_white;
        return {a, b};
      end
    endcase
  endfunction

  // Output check
  always @(posedge clk) begin
    raster_word_t e;
    if (!rst && word_valid && word_ready) begin
      words_seen++;
      if (raster_q.size() == 0) begin
        flag("word with nothing expected", out_word, 0);
      end else begin
        e = raster_q.pop_front();
        if (out_word !== e.word)   flag("out_word", out_word, e.word);
        if (bytes_valid !== e.bv)  flag("bytes_valid", bytes_valid, e.bv);
        if (run_last !== e.rl)     flag("run_last", run_last, e.rl);
        if (job_last !== e.jl)     flag("job_last", job_last, e.jl);
      end
    end
  end

  // Receiver stalls; one long hold-off while bytes keep coming
  initial begin
    int stretch;
    int mode;
    logic held_off;
    stretch  = 0;
    mode     = 0;
    held_off = 1'b0;
    word_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && words_seen >= 40 && byte_valid) begin
        held_off = 1'b1;
        word_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      if (stretch == 0) begin
        stretch = $urandom_range(10, 100);
        mode = $urandom_range(0, 2);
      end
      stretch--;
      case (mode)
        0: word_ready <= 1'b1;
        1: word_ready <= ($urandom_range(0, 3) != 0);
        default: word_ready <= ($urandom_range(0, 1) != 0);
      endcase
      @(posedge clk);
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    step_t s;
    int k;
    int tweak_at;
    int flavor;

    rst        <= 1'b1;
    byte_valid <= 1'b0;
    data_byte  <= 8'h00;
    cfg_write  <= 1'b0;
    cfg_index  <= iipr_pkg::RegRowCount;
    cfg_data   <= 8'h00;
    sh_rows    = iipr_pkg::RowCountRst;
    sh_hdr_len = iipr_pkg::HeaderLengthRst;
    sh_white   = iipr_pkg::WhiteLevelRst;
    in_file    = 1'b0;
    hdr_seen   = '0;
    col        = '0;
    rows_done  = '0;
    acc_word   = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: init after reset, header skip, header length changed mid-file,
    // zero white level, unused register index, skip resumed mid-row
    add_step(STEP_BYTE, 2'd0, 8'hFF, 27, 1'b1, 16'h1B25);
    add_step(STEP_BYTE, 2'd0, 8'h00, 0, 1'b0, 16'h0000);
    add_step(STEP_REG, iipr_pkg::RegHeaderLength, 8'd0, -1, 1'b0, 16'h0000);
    add_step(STEP_BYTE, 2'd0, 8'h00, 3, 1'b1, 16'h1B2A);
    add_step(STEP_BYTE, 2'd0, 8'hFF, 0, 1'b0, 16'h0000);
    add_step(STEP_BYTE, 2'd0, 8'h0F, 0, 1'b0, 16'h0000);
    add_step(STEP_BYTE, 2'd0, 8'hF0, 1, 1'b1, 16'hF0C3);
    add_step(STEP_REG, iipr_pkg::RegWhiteLevel, 8'd0, -1, 1'b0, 16'h0000);
    add_step(STEP_BYTE, 2'd0, 8'h00, 0, 1'b0, 16'h0000);
    add_step(STEP_BYTE, 2'd0, 8'h00, 0, 1'b0, 16'h0000);
    add_step(STEP_BYTE, 2'd0, 8'h00, 0, 1'b0, 16'h0000);
    add_step(STEP_BYTE, 2'd0, 8'h00, 1, 1'b1, 16'h0000);
    add_step(STEP_REG, 2'd3, 8'hAB, -1, 1'b0, 16'h0000);
    add_step(STEP_REG, iipr_pkg::RegWhiteLevel, 8'd8, -1, 1'b0, 16'h0000);
    add_step(STEP_BYTE, 2'd0, 8'h7F, 0, 1'b0, 16'h0000);
    add_step(STEP_BYTE, 2'd0, 8'h80, 0, 1'b0, 16'h0000);
    add_step(STEP_BYTE, 2'd0, 8'h07, 0, 1'b0, 16'h0000);
    add_step(STEP_BYTE, 2'd0, 8'h8F, 1, 1'b1, 16'hC3F0);
    add_step(STEP_REG, iipr_pkg::RegHeaderLength, 8'd15, -1, 1'b0, 16'h0000);
    add_step(STEP_BYTE, 2'd0, 8'h55, 0, 1'b0, 16'h0000);
    add_step(STEP_BYTE, 2'd0, 8'hAA, 0, 1'b0, 16'h0000);
    add_step(STEP_REG, iipr_pkg::RegHeaderLength, 8'd0, -1, 1'b0, 16'h0000);
    add_step(STEP_REG, iipr_pkg::RegRowCount, 8'd1, -1, 1'b0, 16'h0000);

    burst_left = $urandom_range(1, 48);
    foreach (steps[i]) begin
      s = steps[i];
      if (s.kind == STEP_REG) begin
        settle();
        reg_write(s.idx, s.data);
      end else begin
        send_beat(s.data);
        if (s.exp_n >= 0 && run_len != s.exp_n) flag("word count of step", run_len, s.exp_n);
        if (s.chk_w && run_first != s.exp_w) flag("first word of step", run_first, s.exp_w);
        pace();
      end
    end

    // Random part: finish the open file with mixed byte flavors and one
    // register change part way through
    flavor   = 0;
    tweak_at = $urandom_range(10, 80);
    k = 0;
    while (in_file) begin
      if (k == tweak_at) begin
        settle();
        reg_write(iipr_pkg::RegWhiteLevel, 8'($urandom_range(0, 15)));
      end
      if ($urandom_range(0, 15) == 0) flavor = $urandom_range(0, 2);
      send_beat(pick_byte(flavor));
      pace();
      k++;
    end

    // Start of a second file: init again after the end sequence
    settle();
    reg_write(iipr_pkg::RegHeaderLength, 8'($urandom_range(0, 3)));
    for (k = 0; k < 6; k++) begin
      send_beat(pick_byte($urandom_range(0, 2)));
      pace();
    end

    settle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && raster_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
